[hdl/tsbrs_pkg.sv]
// shared codes and controller command type for the two-stack radix sorter
package tsbrs_pkg;

    localparam logic [1:0] OPC_CLEAR   = 2'd0;
    localparam logic [1:0] OPC_LOAD    = 2'd1;
    localparam logic [1:0] OPC_ADVANCE = 2'd2;

    localparam logic [1:0] OP_ROT   = 2'd0;
    localparam logic [1:0] OP_PUSHB = 2'd1;
    localparam logic [1:0] OP_PUSHA = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] PH_LOADING  = 2'd0;
    localparam logic [1:0] PH_SCANNING = 2'd1;
    localparam logic [1:0] PH_DRAINING = 2'd2;
    localparam logic [1:0] PH_DONE     = 2'd3;

    typedef struct packed {
        logic capture;
        logic read;
        logic exec;
    } tsbrs_cmd_t;

endpackage

[hdl/tsbrs_ctrl.sv]
// handshake and sequencing state machine of the radix sorter
module tsbrs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output tsbrs_pkg::tsbrs_cmd_t cmd
);
    import tsbrs_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign slot_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.read    = 1'b0;
        cmd.exec    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ: begin
                cmd.read   = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (slot_free) begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.exec) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hdl/tsbrs_datapath.sv]
// stack memories, pass counters and result register of the radix sorter
module tsbrs_datapath #(
    parameter int DEPTH     = 64,
    parameter int RANK_BITS = 6
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tsbrs_pkg::tsbrs_cmd_t cmd,
    input  logic [1:0]            in_opcode,
    input  logic [RANK_BITS-1:0]  in_rank,
    output logic [1:0]            operation,
    output logic [RANK_BITS-1:0]  moved_rank,
    output logic                  done_res
);
    import tsbrs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = $clog2(RANK_BITS + 1);
    localparam int SW = AW + 2;

    logic [RANK_BITS-1:0] a_mem [DEPTH];
    logic [RANK_BITS-1:0] b_mem [DEPTH];
    logic [RANK_BITS-1:0] a_rd_reg;
    logic [RANK_BITS-1:0] b_rd_reg;

    logic [1:0]           opcode_reg;
    logic [RANK_BITS-1:0] rank_reg;

    logic [AW-1:0]        a_head_reg,  a_head_next;
    logic [CW-1:0]        a_count_reg, a_count_next;
    logic [CW-1:0]        b_count_reg, b_count_next;
    logic [RANK_BITS-1:0] largest_reg, largest_next;
    logic [PW-1:0]        pass_bit_reg, pass_bit_next;
    logic [PW-1:0]        pass_total_reg, pass_total_next;
    logic [CW-1:0]        scan_pos_reg, scan_pos_next;
    logic [1:0]           phase_reg, phase_next;

    logic [1:0]           op_reg, op_next;
    logic [RANK_BITS-1:0] moved_reg, moved_next;
    logic                 done_reg, done_next;

    logic                 a_we;
    logic [AW-1:0]        a_waddr;
    logic [RANK_BITS-1:0] a_wdata;
    logic                 b_we;
    logic [AW-1:0]        b_waddr;
    logic [RANK_BITS-1:0] b_wdata;
    logic [CW-1:0]        b_top;
    logic [AW-1:0]        b_raddr;

    logic [PW-1:0]        bit_len;
    logic [SW-1:0]        tail_sum;
    logic [AW-1:0]        tail_addr;
    logic [AW-1:0]        head_inc;
    logic [AW-1:0]        head_dec;

    assign b_top   = b_count_reg - CW'(1);
    assign b_raddr = b_top[AW-1:0];

    assign head_inc = (a_head_reg == AW'(DEPTH - 1)) ? '0 : a_head_reg + AW'(1);
    assign head_dec = (a_head_reg == '0) ? AW'(DEPTH - 1) : a_head_reg - AW'(1);

    always_comb begin
        tail_sum = SW'(a_head_reg) + SW'(a_count_reg);
        if (tail_sum >= SW'(DEPTH)) begin
            tail_sum = tail_sum - SW'(DEPTH);
        end
        tail_addr = tail_sum[AW-1:0];
    end

    always_comb begin
        bit_len = '0;
        for (int i = 0; i < RANK_BITS; i++) begin
            if (largest_reg[i]) begin
                bit_len = PW'(i + 1);
            end
        end
    end

    always_comb begin
        logic [1:0]           ph;
        logic [RANK_BITS-1:0] shifted;

        a_head_next     = a_head_reg;
        a_count_next    = a_count_reg;
        b_count_next    = b_count_reg;
        largest_next    = largest_reg;
        pass_bit_next   = pass_bit_reg;
        pass_total_next = pass_total_reg;
        scan_pos_next   = scan_pos_reg;
        ph              = phase_reg;
        op_next         = OP_NONE;
        moved_next      = '0;
        a_we            = 1'b0;
        a_waddr         = tail_addr;
        a_wdata         = rank_reg;
        b_we            = 1'b0;
        b_waddr         = b_count_reg[AW-1:0];
        b_wdata         = a_rd_reg;
        shifted         = a_rd_reg >> pass_bit_reg;

        unique case (opcode_reg)
            OPC_CLEAR: begin
                a_head_next     = '0;
                a_count_next    = '0;
                b_count_next    = '0;
                largest_next    = '0;
                pass_bit_next   = '0;
                pass_total_next = '0;
                scan_pos_next   = '0;
                ph              = PH_LOADING;
            end
            OPC_LOAD: begin
                if (phase_reg == PH_LOADING && a_count_reg < CW'(DEPTH)) begin
                    a_we         = 1'b1;
                    a_count_next = a_count_reg + CW'(1);
                    if (rank_reg > largest_reg) begin
                        largest_next = rank_reg;
                    end
                end
            end
            OPC_ADVANCE: begin
                if (ph == PH_LOADING) begin
                    pass_total_next = bit_len;
                    pass_bit_next   = '0;
                    scan_pos_next   = '0;
                    shifted         = a_rd_reg;
                    ph = (bit_len == '0 || a_count_reg == '0) ? PH_DONE : PH_SCANNING;
                end
                if (ph == PH_SCANNING) begin
                    moved_next  = a_rd_reg;
                    a_head_next = head_inc;
                    if (shifted[0]) begin
                        a_we    = 1'b1;
                        a_wdata = a_rd_reg;
                        op_next = OP_ROT;
                    end else begin
                        b_we         = 1'b1;
                        b_count_next = b_count_reg + CW'(1);
                        a_count_next = a_count_reg - CW'(1);
                        op_next      = OP_PUSHB;
                    end
                    scan_pos_next = scan_pos_next + CW'(1);
                    if ((CW+1)'(scan_pos_next) >=
                        (CW+1)'(a_count_next) + (CW+1)'(b_count_next)) begin
                        ph = PH_DRAINING;
                    end
                end else if (ph == PH_DRAINING) begin
                    b_count_next = b_top;
                    a_head_next  = head_dec;
                    a_count_next = a_count_reg + CW'(1);
                    a_we         = 1'b1;
                    a_waddr      = head_dec;
                    a_wdata      = b_rd_reg;
                    moved_next   = b_rd_reg;
                    op_next      = OP_PUSHA;
                end
                if (ph == PH_DRAINING && b_count_next == '0) begin
                    pass_bit_next = pass_bit_next + PW'(1);
                    scan_pos_next = '0;
                    ph = (pass_bit_next >= pass_total_next) ? PH_DONE : PH_SCANNING;
                end
            end
            default: begin
            end
        endcase

        phase_next = ph;
        done_next  = (ph == PH_DONE);
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && a_we) begin
            a_mem[a_waddr] <= a_wdata;
        end
        if (cmd.read) begin
            a_rd_reg <= a_mem[a_head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && b_we) begin
            b_mem[b_waddr] <= b_wdata;
        end
        if (cmd.read) begin
            b_rd_reg <= b_mem[b_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            opcode_reg <= in_opcode;
            rank_reg   <= in_rank;
        end
        if (cmd.exec) begin
            op_reg    <= op_next;
            moved_reg <= moved_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_head_reg     <= '0;
            a_count_reg    <= '0;
            b_count_reg    <= '0;
            largest_reg    <= '0;
            pass_bit_reg   <= '0;
            pass_total_reg <= '0;
            scan_pos_reg   <= '0;
            phase_reg      <= PH_LOADING;
        end else if (cmd.exec) begin
            a_head_reg     <= a_head_next;
            a_count_reg    <= a_count_next;
            b_count_reg    <= b_count_next;
            largest_reg    <= largest_next;
            pass_bit_reg   <= pass_bit_next;
            pass_total_reg <= pass_total_next;
            scan_pos_reg   <= scan_pos_next;
            phase_reg      <= phase_next;
        end
    end

    assign operation  = op_reg;
    assign moved_rank = moved_reg;
    assign done_res   = done_reg;

endmodule

[hdl/two_stack_binary_radix_sort.sv]
// top level of the two-stack binary radix sorter
//
//  channel   direction  tuser            tdata
//  s_        in         opcode [1:0]     rank [RANK_BITS-1:0]
//  m_        out        operation [1:0]  moved_rank, then done_res above it
//
//  every transaction passes through three steps: capture, stack memory read, execute
//  the stack memories have a registered read port, which sets the read cycle
//  a new transaction is taken while the previous result still waits on m_
//  a stalled result holds the execute step until m_tready frees the register
//  aresetn clears counters and phase; stack contents need no clearing
module two_stack_binary_radix_sort #(
    parameter int DEPTH     = 64,
    parameter int RANK_BITS = 6
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((RANK_BITS+7)/8)*8-1:0]       s_tdata,  // rank
    input  logic [1:0]                           s_tuser,  // opcode
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((RANK_BITS+8)/8)*8-1:0]       m_tdata,  // moved_rank, done_res
    output logic [1:0]                           m_tuser   // operation
);
    import tsbrs_pkg::*;

    localparam int MW = ((RANK_BITS + 8) / 8) * 8;

    tsbrs_cmd_t           cmd;
    logic [RANK_BITS-1:0] moved_rank;
    logic                 done_res;

    tsbrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tsbrs_datapath #(
        .DEPTH     (DEPTH),
        .RANK_BITS (RANK_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_opcode  (s_tuser),
        .in_rank    (s_tdata[RANK_BITS-1:0]),
        .operation  (m_tuser),
        .moved_rank (moved_rank),
        .done_res   (done_res)
    );

    assign m_tdata = MW'({done_res, moved_rank});

endmodule

[hdl/tsbrs_checker.sv]
// port-level checks of the radix sorter, bound to the top level
module tsbrs_checker #(
    parameter int RANK_BITS = 6
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [((RANK_BITS+8)/8)*8-1:0] m_tdata,
    input logic [1:0]                     m_tuser
);
    import tsbrs_pkg::*;

    a_reset_empties_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction taken while one is in work");

    a_none_moves_nothing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == OP_NONE |-> m_tdata[RANK_BITS-1:0] == '0)
        else $error("no-operation result carries a rank");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind two_stack_binary_radix_sort tsbrs_checker #(
    .RANK_BITS (RANK_BITS)
) u_tsbrs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
